[design/fixed_to_decimal_ascii_macros.svh]
// assertion helpers for the top-level design file
`ifndef FIXED_TO_DECIMAL_ASCII_MACROS_SVH
`define FIXED_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define FDA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fixed_to_decimal_ascii: check failed");

// next-cycle implication
`define FDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fixed_to_decimal_ascii: check failed");

`endif

[design/fda_pkg.sv]
`default_nettype none

package fda_pkg;

    localparam int VAL_W           = 48;
    localparam int FRAC_BITS       = 16;
    localparam int INT_DIGITS_MAX  = 10;
    localparam int FRAC_DIGITS_MAX = 6;

    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] FRAC_DIGITS_RST = 3'd2;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic REG_FRAC_DIGITS = 1'b0;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_POINT = 8'd46;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    function automatic longint unsigned pow10(input int unsigned e);
        longint unsigned p;
        p = 64'd1;
        for (int unsigned k = 0; k < e; k++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    typedef struct packed {
        logic start;
        logic sat;
        logic shift;
    } t_bcd_cmd;

    typedef struct packed {
        logic       busy;
        logic [3:0] top_digit;
    } t_bcd_stat;

    typedef struct packed {
        logic load;
        logic step;
    } t_frac_cmd;

endpackage

`default_nettype wire

[design/fda_if.sv]
`default_nettype none

interface fda_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [fda_pkg::VAL_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface fda_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

[design/fda_apb_cfg.sv]
`default_nettype none

module fda_apb_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fda_pkg::APB_AW-1:0]    paddr,
    input  wire logic [fda_pkg::APB_DW-1:0]    pwdata,
    output logic      [fda_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output logic      [fda_pkg::CFG_W-1:0]     o_frac_digits
);

    logic                        w_idx;
    logic                        w_wr;
    logic [fda_pkg::CFG_W-1:0]   r_frac_digits;

    // register index sits above the byte offset
    assign w_idx  = paddr[fda_pkg::APB_AW-1];
    assign w_wr   = psel && penable && pwrite && (w_idx == fda_pkg::REG_FRAC_DIGITS);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_digits <= fda_pkg::FRAC_DIGITS_RST;
        end else if (w_wr) begin
            r_frac_digits <= pwdata[fda_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == fda_pkg::REG_FRAC_DIGITS) begin
            prdata = {{(fda_pkg::APB_DW-fda_pkg::CFG_W){1'b0}}, r_frac_digits};
        end
    end

    assign o_frac_digits = r_frac_digits;

endmodule

`default_nettype wire

[design/fda_bcd_conv.sv]
`default_nettype none

module fda_bcd_conv #(
    parameter int IW   = 31,
    parameter int NDIG = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fda_pkg::t_bcd_cmd  i_cmd,
    input  wire logic [IW-1:0]      i_ipart,
    output fda_pkg::t_bcd_stat      o_stat
);

    localparam int CW = $clog2(IW + 1);

    logic [3:0]    r_digits [NDIG];
    logic [3:0]    w_adj    [NDIG];
    logic [IW-1:0] r_bits;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            w_adj[i] = (r_digits[i] >= 4'd5) ? r_digits[i] + 4'd3 : r_digits[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= !i_cmd.sat;
            r_cnt  <= CW'(IW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_bits <= i_ipart;
            for (int i = 0; i < NDIG; i++) begin
                r_digits[i] <= i_cmd.sat ? 4'd9 : 4'd0;
            end
        end else if (r_busy) begin
            // one binary bit enters per cycle, msb first
            r_bits      <= {r_bits[IW-2:0], 1'b0};
            r_digits[0] <= {w_adj[0][2:0], r_bits[IW-1]};
            for (int i = 1; i < NDIG; i++) begin
                r_digits[i] <= {w_adj[i][2:0], w_adj[i-1][3]};
            end
        end else if (i_cmd.shift) begin
            // move the next digit to the top for output
            r_digits[0] <= 4'd0;
            for (int i = 1; i < NDIG; i++) begin
                r_digits[i] <= r_digits[i-1];
            end
        end
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.top_digit = r_digits[NDIG-1];

endmodule

`default_nettype wire

[design/fda_frac_digit.sv]
`default_nettype none

module fda_frac_digit #(
    parameter int FB = 16
) (
    input  wire logic                i_clk,
    input  wire fda_pkg::t_frac_cmd  i_cmd,
    input  wire logic [FB-1:0]       i_fpart,
    output logic      [3:0]          o_digit
);

    logic [FB-1:0] r_frac;
    logic [FB+3:0] w_x10;

    // times ten as 8x + 2x, the integer part is the next digit
    assign w_x10   = {1'b0, r_frac, 3'b000} + {3'b000, r_frac, 1'b0};
    assign o_digit = w_x10[FB+3:FB];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frac <= i_fpart;
        end else if (i_cmd.step) begin
            r_frac <= w_x10[FB-1:0];
        end
    end

endmodule

`default_nettype wire

[design/fixed_to_decimal_ascii.sv]
// channel   dir  handshake        payload
// i_in      in   valid / ready    value (48b signed, FRAC_BITS fraction bits)
// o_out     out  valid / ready    char_code (8b), last_char (1b)
// apb cfg   in   psel / penable   register 0 frac_digits at byte 0
//
// per number: accept, setup in S_PREP and S_START, one bit-serial bcd shift
// per integer bit (none when the integer part saturates), leaving the conversion,
// the leading-zero skips, leaving the skip, and then one step per character
// reset clears the sequencer and the output valid; frac_digits resets to 2
// a stalled output holds its char; the next number is taken while the last stalls
`default_nettype none
`include "fixed_to_decimal_ascii_macros.svh"

module fixed_to_decimal_ascii #(
    parameter int FRAC_BITS       = fda_pkg::FRAC_BITS,
    parameter int INT_DIGITS_MAX  = fda_pkg::INT_DIGITS_MAX,
    parameter int FRAC_DIGITS_MAX = fda_pkg::FRAC_DIGITS_MAX
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    fda_in_if.sink                             i_in,
    fda_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fda_pkg::APB_AW-1:0]    paddr,
    input  wire logic [fda_pkg::APB_DW-1:0]    pwdata,
    output logic      [fda_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    localparam int VAL_W = fda_pkg::VAL_W;
    localparam int MAG_W = VAL_W - 1;
    localparam int IW    = MAG_W - FRAC_BITS;
    localparam int ICW   = $clog2(INT_DIGITS_MAX + 1);
    localparam int FCW   = $clog2(FRAC_DIGITS_MAX + 1);
    localparam longint unsigned LIMIT = fda_pkg::pow10(INT_DIGITS_MAX) - 64'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_START,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_INT,
        S_POINT,
        S_FRAC
    } t_state;

    t_state                     r_state;
    logic [VAL_W-1:0]           r_raw;
    logic                       r_neg;
    logic [MAG_W-1:0]           r_mag;
    logic [ICW-1:0]             r_int_left;
    logic [FCW-1:0]             r_frac_left;
    logic                       r_show_frac;
    logic                       r_out_valid;
    logic [7:0]                 r_char;
    logic                       r_last;

    logic [VAL_W-1:0]           w_neg_raw;
    logic [MAG_W-1:0]           n_mag;
    logic [IW-1:0]              w_ipart;
    logic [FRAC_BITS-1:0]       w_fpart;
    logic                       w_sat;
    logic [fda_pkg::CFG_W-1:0]  w_frac_digits;
    logic [3:0]                 w_fd4;
    logic [FCW-1:0]             w_d;
    logic                       w_out_free;
    logic                       w_emit;
    logic                       w_skip;
    logic [3:0]                 w_frac_digit;
    logic                       w_char_ok;
    logic                       w_frac_phase;
    logic                       w_text_phase;
    logic                       w_int_final;
    fda_pkg::t_bcd_cmd          w_bcd_cmd;
    fda_pkg::t_bcd_stat         w_bcd_stat;
    fda_pkg::t_frac_cmd         w_frac_cmd;

    fda_apb_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_frac_digits (w_frac_digits)
    );

    // magnitude, the most negative value saturates to all ones
    assign w_neg_raw = ~r_raw + VAL_W'(1);
    always_comb begin
        if (r_raw[VAL_W-1]) begin
            n_mag = w_neg_raw[VAL_W-1] ? {MAG_W{1'b1}} : w_neg_raw[MAG_W-1:0];
        end else begin
            n_mag = r_raw[MAG_W-1:0];
        end
    end

    assign w_ipart = r_mag[MAG_W-1:FRAC_BITS];
    assign w_fpart = r_mag[FRAC_BITS-1:0];
    assign w_sat   = {{(64-IW){1'b0}}, w_ipart} > LIMIT;

    assign w_fd4 = {1'b0, w_frac_digits};
    assign w_d   = (w_fd4 > 4'(FRAC_DIGITS_MAX)) ? FCW'(FRAC_DIGITS_MAX) : FCW'(w_fd4);

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_emit     = ((r_state == S_SIGN) || (r_state == S_INT)
                      || (r_state == S_POINT) || (r_state == S_FRAC)) && w_out_free;
    assign w_skip     = (w_bcd_stat.top_digit == 4'd0) && (r_int_left > ICW'(1));

    assign w_bcd_cmd.start = (r_state == S_START);
    assign w_bcd_cmd.sat   = w_sat;
    assign w_bcd_cmd.shift = ((r_state == S_SKIP) && w_skip)
                          || ((r_state == S_INT) && w_out_free);

    assign w_frac_cmd.load = (r_state == S_START);
    assign w_frac_cmd.step = (r_state == S_FRAC) && w_out_free;

    fda_bcd_conv #(
        .IW   (IW),
        .NDIG (INT_DIGITS_MAX)
    ) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_bcd_cmd),
        .i_ipart (w_ipart),
        .o_stat  (w_bcd_stat)
    );

    fda_frac_digit #(
        .FB (FRAC_BITS)
    ) u_frac (
        .i_clk   (i_clk),
        .i_cmd   (w_frac_cmd),
        .i_fpart (w_fpart),
        .o_digit (w_frac_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_raw   <= i_in.value;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_neg   <= r_raw[VAL_W-1];
                    r_mag   <= n_mag;
                    r_state <= S_START;
                end
                S_START: begin
                    r_int_left  <= ICW'(INT_DIGITS_MAX);
                    r_frac_left <= w_d;
                    r_show_frac <= (w_fpart != '0) && (w_d != '0);
                    r_state     <= S_CONV;
                end
                S_CONV: begin
                    if (!w_bcd_stat.busy) begin
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (w_skip) begin
                        r_int_left <= r_int_left - ICW'(1);
                    end else begin
                        r_state <= r_neg ? S_SIGN : S_INT;
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_char      <= fda_pkg::ASCII_MINUS;
                        r_last      <= 1'b0;
                        r_state     <= S_INT;
                    end
                end
                S_INT: begin
                    if (w_out_free) begin
                        r_char      <= fda_pkg::ASCII_ZERO + {4'd0, w_bcd_stat.top_digit};
                        r_last      <= (r_int_left == ICW'(1)) && !r_show_frac;
                        r_int_left  <= r_int_left - ICW'(1);
                        if (r_int_left == ICW'(1)) begin
                            r_state <= r_show_frac ? S_POINT : S_IDLE;
                        end
                    end
                end
                S_POINT: begin
                    if (w_out_free) begin
                        r_char      <= fda_pkg::ASCII_POINT;
                        r_last      <= 1'b0;
                        r_state     <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    if (w_out_free) begin
                        r_char      <= fda_pkg::ASCII_ZERO + {4'd0, w_frac_digit};
                        r_last      <= (r_frac_left == FCW'(1));
                        r_frac_left <= r_frac_left - FCW'(1);
                        if (r_frac_left == FCW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

    assign w_char_ok    = ((r_char >= fda_pkg::ASCII_ZERO) && (r_char <= fda_pkg::ASCII_ZERO + 8'd9))
                       || (r_char == fda_pkg::ASCII_POINT) || (r_char == fda_pkg::ASCII_MINUS);
    assign w_frac_phase = (r_state == S_POINT) || (r_state == S_FRAC);
    assign w_text_phase = (r_state == S_SKIP) || (r_state == S_SIGN) || (r_state == S_INT);
    assign w_int_final  = (r_state == S_INT) && w_out_free && (r_int_left == ICW'(1))
                       && !r_show_frac;

    `FDA_ASSERT_IMPL(a_char_legal, i_clk, i_rst_n, r_out_valid, w_char_ok)
    `FDA_ASSERT_IMPL(a_frac_only_shown, i_clk, i_rst_n, w_frac_phase, r_show_frac)
    `FDA_ASSERT_IMPL(a_bcd_done, i_clk, i_rst_n, w_text_phase, !w_bcd_stat.busy)
    `FDA_ASSERT_NEXT(a_int_last, i_clk, i_rst_n, w_int_final, r_out_valid && r_last && i_in.ready)

endmodule

`default_nettype wire
